/* design/line_raster_to_page_buffer_macros.svh */
// assertion macros for the line rasterizer
// used by modules that need clk and rst_n in scope
`ifndef LINE_RASTER_TO_PAGE_BUFFER_MACROS_SVH
`define LINE_RASTER_TO_PAGE_BUFFER_MACROS_SVH

// same-cycle implication
`define LRPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lrpb_pkg.sv */
// shared types and constants for the line rasterizer
// no dependencies
package lrpb_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned ERR_W   = 12;
  localparam int unsigned RADDR_W = 10;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned ACT_W   = 2;

  localparam logic [ACT_W-1:0] ACT_LINE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

  localparam logic [DATA_W-1:0] BYTE_ON  = 8'hFF;
  localparam logic [DATA_W-1:0] BYTE_OFF = 8'h00;

  localparam int unsigned PAGE_ROWS = 8;

  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic [COORD_W-1:0]      ex;
    logic [COORD_W-1:0]      ey;
    logic [COORD_W-1:0]      dx;
    logic [COORD_W-1:0]      dy;
    logic                    sx_neg;
    logic                    sy_neg;
    logic signed [ERR_W-1:0] err;
  } walk_t;

  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [ERR_W-1:0] err;
    logic                    last;
  } step_t;

endpackage

/* design/lrpb_if.sv */
// valid/ready channel interfaces for command, result and config
// depends on lrpb_pkg
interface lrpb_in_if import lrpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic               pixel_on;
  logic [RADDR_W-1:0] read_address;

  modport source (output valid, action, start_x, start_y, end_x, end_y, pixel_on,
                  read_address, input ready);
  modport sink (input valid, action, start_x, start_y, end_x, end_y, pixel_on,
                read_address, output ready);
endinterface

interface lrpb_out_if import lrpb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              read_valid;

  modport source (output valid, read_data, read_valid, input ready);
  modport sink (input valid, read_data, read_valid, output ready);
endinterface

interface lrpb_cfg_if;
  logic valid;
  logic ready;
  logic invert_pixels;

  modport source (output valid, invert_pixels, input ready);
  modport sink (input valid, invert_pixels, output ready);
endinterface

/* design/lrpb_store.sv */
// page-organized frame store, one write and one registered read per cycle
// no package dependencies
module lrpb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/lrpb_step.sv */
// one bresenham error-term step, shared by every pixel of a line
// depends on lrpb_pkg
module lrpb_step import lrpb_pkg::*; (
  input  walk_t cur,
  output step_t nxt
);

  logic signed [ERR_W:0]   twice;
  logic signed [ERR_W:0]   neg_dy;
  logic signed [ERR_W:0]   pos_dx;
  logic                    x_move;
  logic                    y_move;
  logic signed [ERR_W-1:0] err_a;

  assign twice  = {cur.err, 1'b0};
  assign neg_dy = -$signed({{(ERR_W+1-COORD_W){1'b0}}, cur.dy});
  assign pos_dx = $signed({{(ERR_W+1-COORD_W){1'b0}}, cur.dx});
  assign x_move = twice > neg_dy;
  assign y_move = twice < pos_dx;

  always_comb begin
    err_a = x_move ? cur.err - $signed({{(ERR_W-COORD_W){1'b0}}, cur.dy}) : cur.err;
    nxt.err = y_move ? err_a + $signed({{(ERR_W-COORD_W){1'b0}}, cur.dx}) : err_a;
    nxt.x = cur.x;
    nxt.y = cur.y;
    if (x_move) begin
      nxt.x = cur.sx_neg ? cur.x - 8'd1 : cur.x + 8'd1;
    end
    if (y_move) begin
      nxt.y = cur.sy_neg ? cur.y - 8'd1 : cur.y + 8'd1;
    end
    nxt.last = (cur.x == cur.ex) && (cur.y == cur.ey);
  end

endmodule

/* design/line_raster_to_page_buffer.sv */
// a read passes RDATA, DONE; a line LREAD, LWRITE per pixel, DONE; a fill FILL, DONE
// one read-modify-write per pixel through the store sets the line rate
// a new command is taken only once the previous one is finished
// after reset the store is swept to zero, one byte per cycle (WIDTH*ceil(HEIGHT/8))
// no command is taken during that sweep; config writes are taken at any time
module line_raster_to_page_buffer import lrpb_pkg::*; #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input logic           clk,
  input logic           rst_n,
  lrpb_in_if.sink       in_ch,
  lrpb_out_if.source    out_ch,
  lrpb_cfg_if.sink      cfg_ch
);
  `include "line_raster_to_page_buffer_macros.svh"

  localparam int DEPTH = WIDTH * ((HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LREAD  = 7'b0000100,
    ST_LWRITE = 7'b0001000,
    ST_FILL   = 7'b0010000,
    ST_RDATA  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  walk_t             walk_r, walk_nxt;
  step_t             step;
  logic              lit_r, lit_nxt;
  logic              invert_r;
  logic              fill_val_r, fill_val_nxt;
  logic [AW-1:0]     fill_cnt_r, fill_cnt_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_rvalid_r, out_rvalid_nxt;

  logic              in_xfer;
  logic              out_free;
  logic [AW-1:0]     pix_addr;
  logic              pix_on;
  logic [7:0]        pix_mask;
  logic [AW-1:0]     st_raddr;
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [DATA_W-1:0] st_wdata;
  logic [DATA_W-1:0] st_rdata;

  lrpb_step u_step (
    .cur (walk_r),
    .nxt (step)
  );

  lrpb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .raddr (st_raddr),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign pix_addr = AW'(32'(walk_r.x) + 32'(walk_r.y[7:3]) * WIDTH);
  assign pix_on   = (9'(walk_r.x) < 9'(WIDTH)) && (9'(walk_r.y) < 9'(HEIGHT));
  assign pix_mask = 8'(1) << walk_r.y[2:0];

  always_comb begin
    state_nxt      = state_r;
    walk_nxt       = walk_r;
    lit_nxt        = lit_r;
    fill_val_nxt   = fill_val_r;
    fill_cnt_nxt   = fill_cnt_r;
    rd_ok_nxt      = rd_ok_r;
    res_data_nxt   = res_data_r;
    res_valid_nxt  = res_valid_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    out_rvalid_nxt = out_rvalid_r;
    st_raddr       = pix_addr;
    st_we          = 1'b0;
    st_waddr       = fill_cnt_r;
    st_wdata       = fill_val_r ? BYTE_ON : BYTE_OFF;

    unique case (state_r)
      ST_CLEAR, ST_FILL: begin
        st_we        = 1'b1;
        fill_cnt_nxt = fill_cnt_r + AW'(1);
        if (fill_cnt_r == AW'(DEPTH - 1)) begin
          fill_cnt_nxt = '0;
          state_nxt    = (state_r == ST_CLEAR) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        st_raddr      = AW'(in_ch.read_address);
        res_data_nxt  = BYTE_OFF;
        res_valid_nxt = 1'b0;
        if (in_xfer) begin
          priority if (in_ch.action == ACT_LINE) begin
            walk_nxt.x      = in_ch.start_x;
            walk_nxt.y      = in_ch.start_y;
            walk_nxt.ex     = in_ch.end_x;
            walk_nxt.ey     = in_ch.end_y;
            walk_nxt.dx     = (in_ch.end_x > in_ch.start_x) ? in_ch.end_x - in_ch.start_x
                                                           : in_ch.start_x - in_ch.end_x;
            walk_nxt.dy     = (in_ch.end_y > in_ch.start_y) ? in_ch.end_y - in_ch.start_y
                                                           : in_ch.start_y - in_ch.end_y;
            walk_nxt.sx_neg = !(in_ch.start_x < in_ch.end_x);
            walk_nxt.sy_neg = !(in_ch.start_y < in_ch.end_y);
            walk_nxt.err    = $signed(ERR_W'(walk_nxt.dx)) - $signed(ERR_W'(walk_nxt.dy));
            lit_nxt         = in_ch.pixel_on ^ invert_r;
            state_nxt       = ST_LREAD;
          end else if (in_ch.action == ACT_FILL) begin
            fill_val_nxt = in_ch.pixel_on;
            fill_cnt_nxt = '0;
            state_nxt    = ST_FILL;
          end else if (in_ch.action == ACT_READ) begin
            rd_ok_nxt = 32'(in_ch.read_address) < DEPTH;
            state_nxt = ST_RDATA;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LREAD: begin
        state_nxt = ST_LWRITE;
      end
      ST_LWRITE: begin
        st_we    = pix_on;
        st_waddr = pix_addr;
        st_wdata = lit_r ? (st_rdata | pix_mask) : (st_rdata & ~pix_mask);
        if (step.last) begin
          state_nxt = ST_DONE;
        end else begin
          walk_nxt.x   = step.x;
          walk_nxt.y   = step.y;
          walk_nxt.err = step.err;
          state_nxt    = ST_LREAD;
        end
      end
      ST_RDATA: begin
        res_data_nxt  = rd_ok_r ? st_rdata : BYTE_OFF;
        res_valid_nxt = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_rvalid_nxt = res_valid_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      fill_cnt_r  <= '0;
      fill_val_r  <= 1'b0;
      invert_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_val_r  <= fill_val_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        invert_r <= cfg_ch.invert_pixels;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    lit_r        <= lit_nxt;
    rd_ok_r      <= rd_ok_nxt;
    res_data_r   <= res_data_nxt;
    res_valid_r  <= res_valid_nxt;
    out_data_r   <= out_data_nxt;
    out_rvalid_r <= out_rvalid_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_data_r;
  assign out_ch.read_valid = out_rvalid_r;

  `LRPB_ASSERT_NEXT(a_read_to_data, in_xfer && (in_ch.action == ACT_READ),
                    state_r == ST_RDATA, "read transfer did not reach data state")
  `LRPB_ASSERT_NOW(a_out_from_done, $rose(out_valid_r), $past(state_r == ST_DONE),
                   "result appeared without a finished command")
  `LRPB_ASSERT_NOW(a_zero_non_read, out_valid_r && !out_rvalid_r, out_data_r == BYTE_OFF,
                   "non-read result carries data")
  `LRPB_ASSERT_NOW(a_write_states, st_we,
                   (state_r == ST_CLEAR) || (state_r == ST_FILL) || (state_r == ST_LWRITE),
                   "store written outside a write state")

endmodule

/* test/lrpb_checker.sv */
// result checker for the line rasterizer: watches the command, result and config channels,
// keeps its own copy of the page store and compares every returned byte in order
// depends on lrpb_pkg and the channel interfaces in lrpb_if.sv
module lrpb_checker import lrpb_pkg::*; #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic clk,
  input  logic rst_n,
  lrpb_in_if   in_ch,
  lrpb_out_if  out_ch,
  lrpb_cfg_if  cfg_ch,
  output int   pending,
  output int   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES       = (HEIGHT + 7) / 8;
  localparam int STORE_BYTES = WIDTH * PAGES;
  localparam int WALK_CAP    = 1024;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              valid;
  } read_back_t;

  logic [DATA_W-1:0] page_store [STORE_BYTES];
  logic              invert_q;
  read_back_t        read_back_q [$];
  read_back_t        got;
  read_back_t        want;
  int                mismatches = 0;

  assign fail_count = mismatches;

  function automatic void set_pixel(int col, int row, logic lit);
    int addr;
    if (col < 0 || row < 0 || col >= WIDTH || row >= HEIGHT) return;
    if (invert_q) lit = ~lit;
    addr = col + (row / PAGE_ROWS) * WIDTH;
    if (addr >= STORE_BYTES) return;
    page_store[addr][row % PAGE_ROWS] = lit;
  endfunction

  function automatic void rasterize_line(int ax, int ay, int bx, int by, logic lit);
    int dx, dy, sx, sy, err, twice, steps;
    dx = (bx > ax) ? bx - ax : ax - bx;
    dy = (by > ay) ? by - ay : ay - by;
    sx = (ax < bx) ? 1 : -1;
    sy = (ay < by) ? 1 : -1;
    err = dx - dy;
    steps = 0;
    set_pixel(bx, by, lit);
    while ((ax != bx || ay != by) && steps < WALK_CAP) begin
      set_pixel(ax, ay, lit);
      twice = err * 2;
      if (twice > -dy) begin
        err -= dy;
        ax += sx;
      end
      if (twice < dx) begin
        err += dx;
        ay += sy;
      end
      steps++;
    end
  endfunction

  function automatic read_back_t apply_command(logic [ACT_W-1:0] act,
                                               logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                               logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                                               logic lit, logic [RADDR_W-1:0] addr);
    read_back_t r;
    r = '0;
    case (act)
      ACT_LINE: begin
        rasterize_line(int'(x0), int'(y0), int'(x1), int'(y1), lit);
      end
      ACT_FILL: begin
        foreach (page_store[i]) page_store[i] = lit ? BYTE_ON : BYTE_OFF;
      end
      ACT_READ: begin
        r.valid = 1'b1;
        if (int'(addr) < STORE_BYTES) r.data = page_store[addr];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (page_store[i]) page_store[i] = BYTE_OFF;
      invert_q = 1'b0;
      read_back_q.delete();
      pending <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) invert_q = cfg_ch.invert_pixels;
      if (out_ch.valid && out_ch.ready) begin
        got.data  = out_ch.read_data;
        got.valid = out_ch.read_valid;
        if (read_back_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, actual data %h read_valid %b",
                   $time, got.data, got.valid);
        end else begin
          want = read_back_q.pop_front();
          if (got.data !== want.data) begin
            mismatches++;
            $display("%0t: read_data expected %h actual %h", $time, want.data, got.data);
          end
          if (got.valid !== want.valid) begin
            mismatches++;
            $display("%0t: read_valid expected %b actual %b", $time, want.valid, got.valid);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        read_back_q.push_back(apply_command(in_ch.action, in_ch.start_x, in_ch.start_y,
                                            in_ch.end_x, in_ch.end_y, in_ch.pixel_on,
                                            in_ch.read_address));
      end
      pending <= read_back_q.size();
    end
  end

endmodule

/* test/tb_line_raster_to_page_buffer.sv */
// top of the line rasterizer testbench: clock, reset, command and config stimulus,
// a randomly stalling result sink, the watchdog and the final verdict
// depends on lrpb_pkg, lrpb_if.sv, lrpb_checker and the line_raster_to_page_buffer RTL
module tb_line_raster_to_page_buffer;
  timeunit 1ns;
  timeprecision 1ps;
  import lrpb_pkg::*;

  localparam int PANEL_W     = 128;
  localparam int PANEL_H     = 64;
  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 175;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic               lit;
    logic [RADDR_W-1:0] addr;
  } cmd_t;

  logic clk;
  logic rst_n;
  int   pending;
  int   fail_count;
  int   send_burst = 0;
  int   recv_burst = 0;
  int   recent_col = 0;
  int   recent_row = 0;

  lrpb_in_if  in_ch ();
  lrpb_out_if out_ch ();
  lrpb_cfg_if cfg_ch ();

  line_raster_to_page_buffer #(.WIDTH(PANEL_W), .HEIGHT(PANEL_H)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lrpb_checker #(.WIDTH(PANEL_W), .HEIGHT(PANEL_H)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic cmd_t line_cmd(int x0, int y0, int x1, int y1, logic lit);
    cmd_t c;
    c = '0;
    c.action = ACT_LINE;
    c.sx = x0[7:0];
    c.sy = y0[7:0];
    c.ex = x1[7:0];
    c.ey = y1[7:0];
    c.lit = lit;
    return c;
  endfunction

  function automatic cmd_t read_cmd(int addr);
    cmd_t c;
    c = '0;
    c.action = ACT_READ;
    c.addr = addr[9:0];
    return c;
  endfunction

  function automatic cmd_t fill_cmd(logic lit);
    cmd_t c;
    c = '0;
    c.action = ACT_FILL;
    c.lit = lit;
    return c;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick, x0, y0, x1, y1;
    c.sx = 8'($urandom);
    c.sy = 8'($urandom);
    c.ex = 8'($urandom);
    c.ey = 8'($urandom);
    c.lit = 1'($urandom);
    c.addr = 10'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      c.action = ACT_LINE;
      if ($urandom_range(0, 4) != 0) begin
        x0 = $urandom_range(0, PANEL_W + 15);
        y0 = $urandom_range(0, PANEL_H + 7);
        if ($urandom_range(0, 1) == 1) begin
          x1 = clamp_coord(x0 + $urandom_range(0, 30) - 15);
          y1 = clamp_coord(y0 + $urandom_range(0, 30) - 15);
        end else begin
          x1 = $urandom_range(0, PANEL_W + 15);
          y1 = $urandom_range(0, PANEL_H + 7);
        end
        c.sx = x0[7:0];
        c.sy = y0[7:0];
        c.ex = x1[7:0];
        c.ey = y1[7:0];
      end
      recent_col = int'(c.sx);
      recent_row = int'(c.sy);
    end else if (pick < 90) begin
      c.action = ACT_READ;
      if ($urandom_range(0, 1) == 1 && recent_col < PANEL_W && recent_row < PANEL_H)
        c.addr = 10'(recent_col + (recent_row / PAGE_ROWS) * PANEL_W);
    end else if (pick < 93) begin
      c.action = ACT_FILL;
    end else begin
      c.action = ACT_UNUSED;
    end
    return c;
  endfunction

  task automatic issue(cmd_t c);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= c.action;
    in_ch.start_x      <= c.sx;
    in_ch.start_y      <= c.sy;
    in_ch.end_x        <= c.ex;
    in_ch.end_y        <= c.ey;
    in_ch.pixel_on     <= c.lit;
    in_ch.read_address <= c.addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_invert(logic v);
    drain();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.invert_pixels <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // result sink with random stalls and two long hold-offs
  initial begin
    int gap;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = pick_gap(recv_burst);
      if (taken == 30 || taken == 500) gap = LONG_HOLD;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_LINE;
    in_ch.start_x        <= '0;
    in_ch.start_y        <= '0;
    in_ch.end_x          <= '0;
    in_ch.end_y          <= '0;
    in_ch.pixel_on       <= 1'b0;
    in_ch.read_address   <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.invert_pixels <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_invert(1'b0);

    issue(read_cmd(0));
    issue(line_cmd(0, 0, 127, 63, 1'b1));
    issue(read_cmd(0));
    issue(read_cmd(1023));
    issue(line_cmd(5, 5, 5, 5, 1'b1));
    issue(read_cmd(5));
    issue(line_cmd(100, 10, 255, 10, 1'b1));
    issue(read_cmd(255));
    issue(line_cmd(200, 200, 255, 255, 1'b1));
    issue(line_cmd(255, 0, 0, 255, 1'b1));
    issue(line_cmd(64, 63, 64, 0, 1'b1));
    issue(read_cmd(960));
    issue(line_cmd(127, 0, 0, 63, 1'b0));
    issue(read_cmd(448));
    issue('{action: ACT_UNUSED, sx: 8'hFF, sy: 8'hFF, ex: 8'hFF, ey: 8'hFF, lit: 1'b1,
            addr: 10'h3FF});
    issue(fill_cmd(1'b1));
    issue(read_cmd(511));
    issue(line_cmd(0, 0, 255, 255, 1'b0));
    issue(read_cmd(0));
    issue(fill_cmd(1'b0));
    issue(read_cmd(1023));

    write_invert(1'b1);
    issue(line_cmd(10, 0, 10, 63, 1'b0));
    issue(read_cmd(10));
    issue(fill_cmd(1'b1));
    issue(line_cmd(0, 0, 127, 0, 1'b1));
    issue(read_cmd(64));

    for (int p = 0; p < PHASES; p++) begin
      write_invert(p[0]);
      repeat (PHASE_ITEMS) issue(random_cmd());
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* line_raster_to_page_buffer.f */
+incdir+design
design/lrpb_pkg.sv
design/lrpb_if.sv
design/lrpb_store.sv
design/lrpb_step.sv
design/line_raster_to_page_buffer.sv
test/lrpb_checker.sv
test/tb_line_raster_to_page_buffer.sv
